// ===== rtl/core/tsf_pkg.sv =====
// Shared constants, codes and helpers for the touch sample filter.
package tsf_pkg;

	localparam int SAMPLES_PER_GROUP = 5;
	localparam int TRIM_DIV          = SAMPLES_PER_GROUP - 2;

	localparam int SMP_W  = 12;
	localparam int POS_W  = 16;
	localparam int GAIN_W = 19;
	localparam int OFS_W  = 16;
	localparam int WIN_W  = 12;
	localparam int FRAC_W = 16;
	localparam int SUM_W  = $clog2(SAMPLES_PER_GROUP * ((1 << SMP_W) - 1) + 1);
	localparam int CNT_W  = $clog2(SAMPLES_PER_GROUP + 1);
	localparam int PROD_W = GAIN_W + SMP_W + 1;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// divide the trimmed sum by TRIM_DIV through a rounded-up reciprocal
	localparam int MEAN_SHIFT = SUM_W + $clog2(TRIM_DIV);
	localparam int RECIP_W    = SUM_W + 1;
	localparam int MPROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] TRIM_RECIP =
		RECIP_W'(((1 << MEAN_SHIFT) + TRIM_DIV - 1) / TRIM_DIV);

	typedef logic [1:0] func_t;
	localparam func_t FUNC_SAMPLE = 2'd0;
	localparam func_t FUNC_PENUP  = 2'd1;
	localparam func_t FUNC_CLEAR  = 2'd2;

	typedef logic [1:0] ev_t;
	localparam ev_t EV_NONE  = 2'd0;
	localparam ev_t EV_SCAN  = 2'd1;
	localparam ev_t EV_PENUP = 2'd2;
	localparam ev_t EV_CLEAR = 2'd3;

	typedef logic [1:0] phase_t;
	localparam phase_t PH_X1 = 2'd0;
	localparam phase_t PH_Y1 = 2'd1;
	localparam phase_t PH_X2 = 2'd2;
	localparam phase_t PH_Y2 = 2'd3;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_RAW_MODE = 3'd0;
	localparam reg_idx_t REG_X_GAIN   = 3'd1;
	localparam reg_idx_t REG_X_OFFSET = 3'd2;
	localparam reg_idx_t REG_Y_GAIN   = 3'd3;
	localparam reg_idx_t REG_Y_OFFSET = 3'd4;
	localparam reg_idx_t REG_WINDOW   = 3'd5;

	localparam logic signed [GAIN_W-1:0] GAIN_RESET = 19'sd65536;
	localparam logic [WIN_W-1:0]         WIN_RESET  = 12'd50;
	localparam logic [POS_W-1:0]         POS_IDLE   = 16'hFFFF;

	// add offset in Q.16, drop fraction, clamp negatives to zero
	function automatic logic [POS_W-1:0] scale_sat(
		input logic signed [PROD_W-1:0] prod,
		input logic signed [OFS_W-1:0]  ofs
	);
		logic [PROD_W:0] t;
		t = {prod[PROD_W-1], prod} + {ofs[OFS_W-1], ofs, {FRAC_W{1'b0}}};
		return t[PROD_W] ? '0 : t[PROD_W-1 -: POS_W];
	endfunction

endpackage

// ===== rtl/core/touch_sample_filter_and_pen_state_top.sv =====
// Touch sample filter and pen state tracker, top level.
//
// Requests are taken on every cycle (busy is always low) and each one moves
// through a fixed six-stage pipeline: a request that gives a result passes
// through v_s1, ev_s2, ev_s3, ev_s4 and ev_s5 before done rises, and results
// leave in request order, one per cycle at most. The receiver cannot hold
// results off: done is high for a single cycle per result, and each result
// stays on the ports only until the next one replaces it. Sample requests only
// give a result when they complete the fourth (Y) group of a scan; pen-up and
// clear-caught requests always give one; function code 3 is dropped. The stages
// are: input register, running sum/min/max, trimmed mean, agreement and
// averaging, gain multiply, offset/saturate and pen state update. Write
// configuration only when no request is in flight.
module touch_sample_filter_and_pen_state_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      func,
	input  logic [tsf_pkg::SMP_W-1:0]       sample,
	output logic                            done,
	output logic                            pressed,
	output logic                            caught,
	output logic                            read_ok,
	output logic [tsf_pkg::POS_W-1:0]       pos_x,
	output logic [tsf_pkg::POS_W-1:0]       pos_y,
	output logic [tsf_pkg::POS_W-1:0]       first_x,
	output logic [tsf_pkg::POS_W-1:0]       first_y,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tsf_pkg::ADDR_W-1:0]      paddr,
	input  logic [tsf_pkg::DATA_W-1:0]      pwdata,
	output logic [tsf_pkg::DATA_W-1:0]      prdata,
	output logic                            pready
);

	localparam int SMP_W   = tsf_pkg::SMP_W;
	localparam int POS_W   = tsf_pkg::POS_W;
	localparam int SUM_W   = tsf_pkg::SUM_W;
	localparam int CNT_W   = tsf_pkg::CNT_W;
	localparam int GAIN_W  = tsf_pkg::GAIN_W;
	localparam int OFS_W   = tsf_pkg::OFS_W;
	localparam int WIN_W   = tsf_pkg::WIN_W;
	localparam int PROD_W  = tsf_pkg::PROD_W;
	localparam int DATA_W  = tsf_pkg::DATA_W;
	localparam int MPROD_W = tsf_pkg::MPROD_W;

	// configuration registers
	logic                     raw_mode_q;
	logic signed [GAIN_W-1:0] x_gain_q;
	logic signed [OFS_W-1:0]  x_offset_q;
	logic signed [GAIN_W-1:0] y_gain_q;
	logic signed [OFS_W-1:0]  y_offset_q;
	logic [WIN_W-1:0]         window_q;
	logic                     cfg_wr;
	tsf_pkg::reg_idx_t        cfg_idx;

	// input register
	logic                     v_s1;
	tsf_pkg::func_t           func_s1;
	logic [SMP_W-1:0]         sample_s1;

	// group accumulation
	logic [CNT_W-1:0]         cnt_q;
	logic [SUM_W-1:0]         sum_q;
	logic [SMP_W-1:0]         min_q;
	logic [SMP_W-1:0]         max_q;
	tsf_pkg::phase_t          phase_q;
	logic [SUM_W-1:0]         sum_n;
	logic [SMP_W-1:0]         min_n;
	logic [SMP_W-1:0]         max_n;
	logic                     grp_end;
	tsf_pkg::ev_t             ev_n;

	logic                     grp_v_s2;
	tsf_pkg::phase_t          grp_phase_s2;
	logic [SUM_W-1:0]         sum_s2;
	logic [SMP_W-1:0]         min_s2;
	logic [SMP_W-1:0]         max_s2;
	tsf_pkg::ev_t             ev_s2;

	// trimmed mean
	logic [SUM_W-1:0]         trimmed;
	logic [MPROD_W-1:0]       mean_prod;
	logic [SMP_W-1:0]         mean;
	logic [SMP_W-1:0]         frx_q;
	logic [SMP_W-1:0]         fry_q;
	logic [SMP_W-1:0]         srx_q;
	logic [SMP_W-1:0]         mean_s3;
	tsf_pkg::ev_t             ev_s3;

	// agreement and average
	logic [SMP_W-1:0]         dx;
	logic [SMP_W-1:0]         dy;
	logic [SMP_W:0]           sx;
	logic [SMP_W:0]           sy;
	logic                     ok_s4;
	logic [SMP_W-1:0]         ax_s4;
	logic [SMP_W-1:0]         ay_s4;
	tsf_pkg::ev_t             ev_s4;

	// gain multiply
	logic                     ok_s5;
	logic [SMP_W-1:0]         ax_s5;
	logic [SMP_W-1:0]         ay_s5;
	logic signed [PROD_W-1:0] px_s5;
	logic signed [PROD_W-1:0] py_s5;
	tsf_pkg::ev_t             ev_s5;

	// offset, saturate and pen state
	logic [POS_W-1:0]         new_x;
	logic [POS_W-1:0]         new_y;
	logic [POS_W-1:0]         cur_x_n;
	logic [POS_W-1:0]         cur_y_n;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// configuration port
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_mode_q <= 1'b0;
			x_gain_q   <= tsf_pkg::GAIN_RESET;
			x_offset_q <= '0;
			y_gain_q   <= tsf_pkg::GAIN_RESET;
			y_offset_q <= '0;
			window_q   <= tsf_pkg::WIN_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				tsf_pkg::REG_RAW_MODE: raw_mode_q <= pwdata[0];
				tsf_pkg::REG_X_GAIN:   x_gain_q   <= pwdata[GAIN_W-1:0];
				tsf_pkg::REG_X_OFFSET: x_offset_q <= pwdata[OFS_W-1:0];
				tsf_pkg::REG_Y_GAIN:   y_gain_q   <= pwdata[GAIN_W-1:0];
				tsf_pkg::REG_Y_OFFSET: y_offset_q <= pwdata[OFS_W-1:0];
				tsf_pkg::REG_WINDOW:   window_q   <= pwdata[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			tsf_pkg::REG_RAW_MODE: prdata = {{(DATA_W-1){1'b0}}, raw_mode_q};
			tsf_pkg::REG_X_GAIN:   prdata = {{(DATA_W-GAIN_W){x_gain_q[GAIN_W-1]}}, x_gain_q};
			tsf_pkg::REG_X_OFFSET: prdata = {{(DATA_W-OFS_W){x_offset_q[OFS_W-1]}}, x_offset_q};
			tsf_pkg::REG_Y_GAIN:   prdata = {{(DATA_W-GAIN_W){y_gain_q[GAIN_W-1]}}, y_gain_q};
			tsf_pkg::REG_Y_OFFSET: prdata = {{(DATA_W-OFS_W){y_offset_q[OFS_W-1]}}, y_offset_q};
			tsf_pkg::REG_WINDOW:   prdata = {{(DATA_W-WIN_W){1'b0}}, window_q};
			default:               prdata = '0;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			func_s1   <= func;
			sample_s1 <= sample;
		end
	end

	// running sum, min and max
	assign sum_n = sum_q + SUM_W'(sample_s1);
	assign min_n = (sample_s1 < min_q) ? sample_s1 : min_q;
	assign max_n = (sample_s1 > max_q) ? sample_s1 : max_q;

	assign grp_end = v_s1 && (func_s1 == tsf_pkg::FUNC_SAMPLE) &&
		(cnt_q == CNT_W'(tsf_pkg::SAMPLES_PER_GROUP - 1));

	always_comb begin
		ev_n = tsf_pkg::EV_NONE;
		if (v_s1) begin
			unique case (func_s1)
				tsf_pkg::FUNC_SAMPLE: begin
					if (grp_end && phase_q == tsf_pkg::PH_Y2) begin
						ev_n = tsf_pkg::EV_SCAN;
					end
				end
				tsf_pkg::FUNC_PENUP: ev_n = tsf_pkg::EV_PENUP;
				tsf_pkg::FUNC_CLEAR: ev_n = tsf_pkg::EV_CLEAR;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			sum_q    <= '0;
			min_q    <= '1;
			max_q    <= '0;
			phase_q  <= tsf_pkg::PH_X1;
			grp_v_s2 <= 1'b0;
			ev_s2    <= tsf_pkg::EV_NONE;
		end else begin
			grp_v_s2 <= grp_end;
			ev_s2    <= ev_n;
			if (v_s1) begin
				unique case (func_s1)
					tsf_pkg::FUNC_SAMPLE: begin
						if (grp_end) begin
							cnt_q   <= '0;
							sum_q   <= '0;
							min_q   <= '1;
							max_q   <= '0;
							phase_q <= phase_q + 2'd1;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
							sum_q <= sum_n;
							min_q <= min_n;
							max_q <= max_n;
						end
					end
					tsf_pkg::FUNC_PENUP: begin
						cnt_q   <= '0;
						sum_q   <= '0;
						min_q   <= '1;
						max_q   <= '0;
						phase_q <= tsf_pkg::PH_X1;
					end
					tsf_pkg::FUNC_CLEAR: ;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_phase_s2 <= phase_q;
		sum_s2       <= sum_n;
		min_s2       <= min_n;
		max_s2       <= max_n;
	end

	// trimmed mean
	assign trimmed   = sum_s2 - SUM_W'(min_s2) - SUM_W'(max_s2);
	assign mean_prod = MPROD_W'(trimmed) * MPROD_W'(tsf_pkg::TRIM_RECIP);
	assign mean      = mean_prod[tsf_pkg::MEAN_SHIFT +: SMP_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frx_q <= '0;
			fry_q <= '0;
			srx_q <= '0;
			ev_s3 <= tsf_pkg::EV_NONE;
		end else begin
			ev_s3 <= ev_s2;
			if (grp_v_s2) begin
				unique case (grp_phase_s2)
					tsf_pkg::PH_X1: frx_q <= mean;
					tsf_pkg::PH_Y1: fry_q <= mean;
					tsf_pkg::PH_X2: srx_q <= mean;
					tsf_pkg::PH_Y2: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		mean_s3 <= mean;
	end

	// agreement and pair average
	assign dx = (frx_q > srx_q) ? (frx_q - srx_q) : (srx_q - frx_q);
	assign dy = (fry_q > mean_s3) ? (fry_q - mean_s3) : (mean_s3 - fry_q);
	assign sx = {1'b0, frx_q} + {1'b0, srx_q};
	assign sy = {1'b0, fry_q} + {1'b0, mean_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s4 <= tsf_pkg::EV_NONE;
		end else begin
			ev_s4 <= ev_s3;
		end
	end

	always_ff @(posedge clk) begin
		ok_s4 <= (dx < window_q) && (dy < window_q);
		ax_s4 <= sx[SMP_W:1];
		ay_s4 <= sy[SMP_W:1];
	end

	// gain multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s5 <= tsf_pkg::EV_NONE;
		end else begin
			ev_s5 <= ev_s4;
		end
	end

	always_ff @(posedge clk) begin
		ok_s5 <= ok_s4;
		ax_s5 <= ax_s4;
		ay_s5 <= ay_s4;
		px_s5 <= $signed({1'b0, ax_s4}) * x_gain_q;
		py_s5 <= $signed({1'b0, ay_s4}) * y_gain_q;
	end

	// offset, saturate, pen state and result
	assign new_x   = raw_mode_q ? POS_W'(ax_s5) : tsf_pkg::scale_sat(px_s5, x_offset_q);
	assign new_y   = raw_mode_q ? POS_W'(ay_s5) : tsf_pkg::scale_sat(py_s5, y_offset_q);
	assign cur_x_n = ok_s5 ? new_x : pos_x;
	assign cur_y_n = ok_s5 ? new_y : pos_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done    <= 1'b0;
			pressed <= 1'b0;
			caught  <= 1'b0;
			read_ok <= 1'b0;
			pos_x   <= '0;
			pos_y   <= '0;
			first_x <= '0;
			first_y <= '0;
		end else begin
			done <= (ev_s5 != tsf_pkg::EV_NONE);
			unique case (ev_s5)
				tsf_pkg::EV_NONE: ;
				tsf_pkg::EV_SCAN: begin
					read_ok <= ok_s5;
					pos_x   <= cur_x_n;
					pos_y   <= cur_y_n;
					if (!pressed) begin
						pressed <= 1'b1;
						caught  <= 1'b1;
						first_x <= cur_x_n;
						first_y <= cur_y_n;
					end
				end
				tsf_pkg::EV_PENUP: begin
					read_ok <= 1'b0;
					if (pressed) begin
						pressed <= 1'b0;
					end else begin
						first_x <= '0;
						first_y <= '0;
						pos_x   <= tsf_pkg::POS_IDLE;
						pos_y   <= tsf_pkg::POS_IDLE;
					end
				end
				tsf_pkg::EV_CLEAR: begin
					read_ok <= 1'b0;
					caught  <= 1'b0;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ev_s5 != tsf_pkg::EV_NONE))
		else $error("result strobe without a request in the last stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && read_ok) |-> pressed)
		else $error("agreed scan left the pen released");

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(tsf_pkg::SAMPLES_PER_GROUP))
		else $error("group sample count overran");

	assert property (@(posedge clk) disable iff (!arst_n)
		grp_v_s2 |-> ((ev_s2 == tsf_pkg::EV_SCAN) == (grp_phase_s2 == tsf_pkg::PH_Y2)))
		else $error("scan end not tied to the last group");

endmodule
